// File: rtl/pec15_pkg.sv
// Shared types, constants and the PEC-15 byte table for the register group checker.
package pec15_pkg;

	localparam int POS_W = 3;
	localparam logic [15:0] PEC_SEED = 16'h0010;
	localparam logic [15:0] PEC_POLY = 16'h4599;

	typedef struct packed {
		logic [15:0]      crc;
		logic [POS_W-1:0] pos;
		logic [7:0]       low_byte;
		logic [7:0]       code_high;
	} state_t;

	typedef struct packed {
		logic [15:0] word_value;
		logic [1:0]  word_index;
		logic        frame_done;
		logic        code_mismatch;
	} result_t;

	// Byte-wise table entry for the polynomial, bit 15 kept.
	function automatic logic [15:0] pec_table_entry(input logic [7:0] idx);
		logic [15:0] r;
		r = {1'b0, idx, 7'b0};
		for (int b = 0; b < 8; b++) begin
			if (r[14]) begin
				r = {r[14:0], 1'b0} ^ PEC_POLY;
			end else begin
				r = {r[14:0], 1'b0};
			end
		end
		return r;
	endfunction

endpackage

// File: rtl/pec15_stream_if.sv
// Valid/ready channel interfaces for reply bytes and check results.
interface pec15_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	logic       frame_start;

	modport source (output valid, output rx_byte, output frame_start, input ready);
	modport sink (input valid, input rx_byte, input frame_start, output ready);
endinterface

interface pec15_result_if;
	logic        valid;
	logic        ready;
	logic [15:0] word_value;
	logic [1:0]  word_index;
	logic        frame_done;
	logic        code_mismatch;

	modport source (output valid, output word_value, output word_index,
		output frame_done, output code_mismatch, input ready);
	modport sink (input valid, input word_value, input word_index,
		input frame_done, input code_mismatch, output ready);
endinterface

// File: rtl/pec15_byte_step.sv
// One byte step of the frame: CRC update, word pairing and final code compare.
module pec15_byte_step #(
	parameter int DATA_BYTES = 6
) (
	input  pec15_pkg::state_t  cur,
	input  logic [7:0]         rx_byte,
	input  logic               frame_start,
	output pec15_pkg::state_t  nxt,
	output logic               res_valid,
	output pec15_pkg::result_t res
);

	localparam logic [pec15_pkg::POS_W-1:0] LAST_DATA_POS = pec15_pkg::POS_W'(DATA_BYTES);

	logic [15:0]                  crc;
	logic [pec15_pkg::POS_W-1:0]  pos;
	logic [7:0]                   addr;
	logic [15:0]                  crc_step;
	logic [15:0]                  received;
	logic [15:0]                  computed;

	// Restart the frame on frame_start before the byte is taken.
	assign crc = frame_start ? pec15_pkg::PEC_SEED : cur.crc;
	assign pos = frame_start ? '0 : cur.pos;

	assign addr     = crc[14:7] ^ rx_byte;
	assign crc_step = {crc[7:0], 8'h00} ^ pec15_pkg::pec_table_entry(addr);
	assign received = {cur.code_high, rx_byte};
	assign computed = {crc[14:0], 1'b0};

	always_comb begin
		nxt       = cur;
		nxt.crc   = crc;
		nxt.pos   = pos;
		res_valid = 1'b0;
		res       = '0;
		if (pos < LAST_DATA_POS) begin
			nxt.crc = crc_step;
			nxt.pos = pos + 1'b1;
			if (!pos[0]) begin
				nxt.low_byte = rx_byte;
			end else begin
				res_valid      = 1'b1;
				res.word_value = {rx_byte, cur.low_byte};
				res.word_index = pos[2:1];
			end
		end else if (pos == LAST_DATA_POS) begin
			nxt.code_high = rx_byte;
			nxt.pos       = pos + 1'b1;
		end else begin
			res_valid         = 1'b1;
			res.frame_done    = 1'b1;
			res.code_mismatch = (received != computed);
			nxt.crc           = pec15_pkg::PEC_SEED;
			nxt.pos           = '0;
		end
	end

endmodule

// File: rtl/pec15_register_group_checker.sv
// Top level of the PEC-15 register group reply checker.
// Takes one reply byte per cycle, back to back, and gives a data word after each data byte pair
// and a status result (frame_done, code_mismatch) after the second code byte. An accepted byte
// is held in the input register, then the table-based CRC byte step writes its result into the
// result register. Throughput is one byte per cycle, set by that single byte step between the
// two registers; the input stalls only while a waiting result is not taken.
module pec15_register_group_checker #(
	parameter int DATA_BYTES = 6
) (
	input  logic                  clk,
	input  logic                  arst_n,
	pec15_byte_if.sink            rx,
	pec15_result_if.source        res
);

	logic                         byte_valid_s1;
	logic [7:0]                   byte_s1;
	logic                         start_s1;
	pec15_pkg::state_t            state_q;
	pec15_pkg::state_t            state_nxt;
	logic                         step_res_valid;
	pec15_pkg::result_t           step_res;
	logic                         out_valid_q;
	pec15_pkg::result_t           out_q;
	logic                         out_free;
	logic                         advance;

	pec15_byte_step #(
		.DATA_BYTES(DATA_BYTES)
	) u_step (
		.cur        (state_q),
		.rx_byte    (byte_s1),
		.frame_start(start_s1),
		.nxt        (state_nxt),
		.res_valid  (step_res_valid),
		.res        (step_res)
	);

	assign out_free = !out_valid_q || res.ready;
	// Advance the held byte unless it has a result and the output slot is busy.
	assign advance  = byte_valid_s1 && (!step_res_valid || out_free);
	assign rx.ready = !byte_valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			byte_valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			byte_s1  <= rx.rx_byte;
			start_s1 <= rx.frame_start;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.crc       <= pec15_pkg::PEC_SEED;
			state_q.pos       <= '0;
			state_q.low_byte  <= '0;
			state_q.code_high <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && step_res_valid) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && step_res_valid) begin
			out_q <= step_res;
		end
	end

	assign res.valid         = out_valid_q;
	assign res.word_value    = out_q.word_value;
	assign res.word_index    = out_q.word_index;
	assign res.frame_done    = out_q.frame_done;
	assign res.code_mismatch = out_q.code_mismatch;

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.pos <= pec15_pkg::POS_W'(DATA_BYTES + 1))
		else $error("byte position ran past the code bytes");

	a_done_rewinds: assert property (@(posedge clk) disable iff (!arst_n)
		advance && step_res_valid && step_res.frame_done |=>
		state_q.pos == '0 && state_q.crc == pec15_pkg::PEC_SEED)
		else $error("status result did not restart the frame");

	a_word_no_error: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_q.frame_done |-> !out_q.code_mismatch)
		else $error("error flag set on a data word");

	a_stall_holds_byte: assert property (@(posedge clk) disable iff (!arst_n)
		byte_valid_s1 && !advance |=> byte_valid_s1 && $stable(byte_s1))
		else $error("held byte lost during output stall");

endmodule

// File: tb/pec15_register_group_checker_tb.sv
// Testbench for the PEC-15 register group checker: directed and random reply frames, scoreboard.
`timescale 1ns / 1ps

module pec15_register_group_checker_tb;

	localparam int DATA_BYTES   = 6;
	localparam int RANDOM_ITEMS = 900;
	localparam int MAX_REPORTS  = 10;

	logic clk;
	logic arst_n;

	pec15_byte_if   rx_ch ();
	pec15_result_if res_ch ();

	pec15_register_group_checker #(
		.DATA_BYTES(DATA_BYTES)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_ch),
		.res    (res_ch)
	);

	// Frame tracker state, mirrors the block.
	logic [15:0] trk_crc;
	logic [2:0]  trk_pos;
	logic [7:0]  trk_low;
	logic [7:0]  trk_code_high;

	pec15_pkg::result_t pending_results[$];
	int      fail_count;
	int      bytes_sent;
	logic    sender_burst;
	logic    sink_burst;

	initial clk = 1'b0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		#400000;
		$display("** pec15_register_group_checker: FAILED **");
		$finish;
	end

	function automatic logic [15:0] pec_table_lookup(input logic [7:0] idx);
		logic [15:0] r;
		logic        top;
		r = 16'(idx) << 7;
		for (int k = 0; k < 8; k++) begin
			top = r[14];
			r = (r << 1) ^ (top ? pec15_pkg::PEC_POLY : 16'h0000);
		end
		return r;
	endfunction

	function automatic logic [15:0] pec_byte_step(input logic [15:0] rem, input logic [7:0] b);
		logic [7:0] addr;
		addr = rem[14:7] ^ b;
		return (rem << 8) ^ pec_table_lookup(addr);
	endfunction

	function automatic logic [15:0] frame_code(input logic [8*DATA_BYTES-1:0] data);
		logic [15:0] rem;
		rem = pec15_pkg::PEC_SEED;
		for (int i = 0; i < DATA_BYTES; i++) begin
			rem = pec_byte_step(rem, data[8*i +: 8]);
		end
		return {rem[14:0], 1'b0};
	endfunction

	function automatic int draw_wait(input logic burst);
		return burst ? 0 : $urandom_range(0, 8);
	endfunction

	task automatic note_failure(input string msg);
		fail_count++;
		if (fail_count <= MAX_REPORTS) begin
			$display("[%0t] mismatch: %s", $realtime, msg);
		end
	endtask

	// Advance the tracker by one accepted byte; queue the result it causes.
	task automatic track_byte(input logic [7:0] b, input logic start);
		pec15_pkg::result_t r;
		logic [2:0]  pos;
		logic [15:0] rx_code;
		if (start) begin
			trk_crc = pec15_pkg::PEC_SEED;
			trk_pos = '0;
		end
		pos = trk_pos;
		r = '0;
		if (pos < DATA_BYTES) begin
			trk_crc = pec_byte_step(trk_crc, b);
			trk_pos = pos + 3'd1;
			if (!pos[0]) begin
				trk_low = b;
			end else begin
				r.word_value = {b, trk_low};
				r.word_index = pos[2:1];
				pending_results.push_back(r);
			end
		end else if (pos == DATA_BYTES) begin
			trk_code_high = b;
			trk_pos = pos + 3'd1;
		end else begin
			rx_code = {trk_code_high, b};
			r.frame_done    = 1'b1;
			r.code_mismatch = (rx_code != {trk_crc[14:0], 1'b0});
			pending_results.push_back(r);
			trk_crc = pec15_pkg::PEC_SEED;
			trk_pos = '0;
		end
	endtask

	task automatic send_byte(input logic [7:0] b, input logic start);
		int gap;
		gap = draw_wait(sender_burst);
		@(negedge clk);
		if (gap > 0) begin
			rx_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		rx_ch.valid       = 1'b1;
		rx_ch.rx_byte     = b;
		rx_ch.frame_start = start;
		@(posedge clk);
		while (!rx_ch.ready) @(posedge clk);
		track_byte(b, start);
		bytes_sent++;
	endtask

	task automatic send_frame(input logic [8*DATA_BYTES-1:0] data, input logic [15:0] code,
			input logic start);
		for (int i = 0; i < DATA_BYTES; i++) begin
			send_byte(data[8*i +: 8], (i == 0) ? start : 1'b0);
		end
		send_byte(code[15:8], 1'b0);
		send_byte(code[7:0], 1'b0);
	endtask

	// Hold off the input until every queued result has been taken.
	task automatic drain_results();
		@(negedge clk);
		rx_ch.valid = 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
	endtask

	function automatic logic [8*DATA_BYTES-1:0] random_data();
		logic [8*DATA_BYTES-1:0] d;
		case ($urandom_range(0, 11))
			0: d = '0;
			1: d = '1;
			default: begin
				for (int i = 0; i < DATA_BYTES; i++) begin
					d[8*i +: 8] = 8'($urandom);
				end
			end
		endcase
		return d;
	endfunction

	task automatic test_clean_and_corrupt_frames();
		logic [8*DATA_BYTES-1:0] d;
		d = '0;
		send_frame(d, frame_code(d), 1'b1);
		// Next frame follows the status beat without a start flag.
		d = '1;
		send_frame(d, frame_code(d) ^ 16'hffff, 1'b0);
	endtask

	task automatic test_restart_mid_frame();
		logic [8*DATA_BYTES-1:0] d;
		send_byte(8'h5a, 1'b1);
		send_byte(8'ha5, 1'b0);
		send_byte(8'h3c, 1'b0);
		d = random_data();
		send_frame(d, frame_code(d), 1'b1);
		drain_results();
	endtask

	task automatic test_random_stream();
		logic [8*DATA_BYTES-1:0] d;
		logic [15:0]             code;
		logic                    start;
		int                      len;
		int                      next_drain;
		next_drain = bytes_sent + 150;
		while (bytes_sent < RANDOM_ITEMS) begin
			if ($urandom_range(0, 5) == 0) sender_burst = ~sender_burst;
			if ($urandom_range(0, 5) == 0) sink_burst = ~sink_burst;
			if ($urandom_range(0, 9) < 7) begin
				d = random_data();
				code = frame_code(d);
				case ($urandom_range(0, 9))
					0, 1: code = code ^ (16'h1 << $urandom_range(0, 15));
					2:    code = 16'($urandom);
					default: ;
				endcase
				// Resync with a start flag when the tracker sits mid-frame.
				start = (trk_pos != 0) ? 1'b1 : 1'($urandom_range(0, 1));
				send_frame(d, code, start);
			end else begin
				len = $urandom_range(1, DATA_BYTES + 3);
				for (int i = 0; i < len; i++) begin
					send_byte(8'($urandom), ($urandom_range(0, 3) == 0));
				end
			end
			if (bytes_sent >= next_drain) begin
				drain_results();
				next_drain = bytes_sent + 150;
			end
		end
	endtask

	// Result sink: random stalls before each beat, except in burst mode.
	initial begin
		int w;
		res_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			w = draw_wait(sink_burst);
			@(negedge clk);
			if (w > 0) begin
				res_ch.ready = 1'b0;
				repeat (w) @(negedge clk);
			end
			res_ch.ready = 1'b1;
			@(posedge clk);
			while (!res_ch.valid) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		pec15_pkg::result_t exp_r;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (pending_results.size() == 0) begin
				note_failure($sformatf("unexpected result value=%h index=%0d done=%b err=%b",
					res_ch.word_value, res_ch.word_index, res_ch.frame_done,
					res_ch.code_mismatch));
			end else begin
				exp_r = pending_results.pop_front();
				if (res_ch.word_value !== exp_r.word_value
						|| res_ch.word_index !== exp_r.word_index
						|| res_ch.frame_done !== exp_r.frame_done
						|| res_ch.code_mismatch !== exp_r.code_mismatch) begin
					note_failure($sformatf({"expected value=%h index=%0d done=%b err=%b, ",
						"got value=%h index=%0d done=%b err=%b"},
						exp_r.word_value, exp_r.word_index, exp_r.frame_done,
						exp_r.code_mismatch, res_ch.word_value, res_ch.word_index,
						res_ch.frame_done, res_ch.code_mismatch));
				end
			end
		end
	end

	initial begin
		int waited;
		arst_n            = 1'b0;
		rx_ch.valid       = 1'b0;
		rx_ch.rx_byte     = '0;
		rx_ch.frame_start = 1'b0;
		trk_crc           = pec15_pkg::PEC_SEED;
		trk_pos           = '0;
		trk_low           = '0;
		trk_code_high     = '0;
		fail_count        = 0;
		bytes_sent        = 0;
		sender_burst      = 1'b0;
		sink_burst        = 1'b0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		test_clean_and_corrupt_frames();
		test_restart_mid_frame();
		test_random_stream();

		@(negedge clk);
		rx_ch.valid = 1'b0;
		waited = 0;
		while (pending_results.size() != 0 && waited < 2000) begin
			@(negedge clk);
			waited++;
		end
		repeat (10) @(negedge clk);
		if (pending_results.size() != 0) begin
			note_failure($sformatf("%0d results never arrived", pending_results.size()));
		end
		if (fail_count == 0) begin
			$display("** pec15_register_group_checker: PASSED **");
		end else begin
			$display("** pec15_register_group_checker: FAILED **");
		end
		$finish;
	end

endmodule
